// ----- rtl/cfba_pkg.sv -----
// ----------------------------------------------------------------------------
// cfba_pkg: shared definitions for the frame bitmap allocator
// Pool geometry, field widths, codes, sequencer states and unit result type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

  // Pool geometry: frames are kept LANES to a map entry.
  localparam int POOL_FRAMES = 512;
  localparam int LANES       = 8;
  localparam int LANE_SH     = $clog2(LANES);
  localparam int ENTRIES     = POOL_FRAMES / LANES;
  localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FIDX_W      = $clog2(POOL_FRAMES);

  // Word field widths.
  localparam int START_W     = 9;
  localparam int COUNT_W     = 10;
  localparam int FIRST_W     = 9;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Internal frame arithmetic holds start + count without overflow.
  localparam int EXT_W = ((FIDX_W > COUNT_W) ? FIDX_W : COUNT_W) + 2;
  localparam logic [EXT_W-1:0] POOL_EXT = EXT_W'(POOL_FRAMES);

  // Request kinds.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result codes.
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_t;

  // Scan result of one map entry.
  typedef struct packed {
    logic             found;
    logic [EXT_W-1:0] first;
    logic [EXT_W-1:0] run;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/cfba_map_ram.sv -----
// ----------------------------------------------------------------------------
// cfba_map_ram: occupancy map storage
// One write and one registered read port; per-entry valid bits make a
// never-written entry read as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_map_ram (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [cfba_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [cfba_pkg::LANES-1:0]   rd_data,
  input  wire logic                         wr_en,
  input  wire logic [cfba_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [cfba_pkg::LANES-1:0]   wr_data
);

  logic [cfba_pkg::LANES-1:0]   mem [cfba_pkg::ENTRIES];
  logic [cfba_pkg::ENTRIES-1:0] valid_r;
  logic [cfba_pkg::LANES-1:0]   rd_mem_r;
  logic                         rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // Unwritten entry: every frame free.
  assign rd_data = rd_valid_r ? rd_mem_r : '0;

endmodule

`default_nettype wire

// ----- rtl/cfba_lane_unit.sv -----
// ----------------------------------------------------------------------------
// cfba_lane_unit: shared per-entry scan and mask unit
// Extends the free run across one map entry and builds the range mask used
// to set or clear frames of that entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_lane_unit (
  input  wire logic [cfba_pkg::LANES-1:0] bits,
  input  wire logic [cfba_pkg::EXT_W-1:0] base,
  input  wire logic [cfba_pkg::EXT_W-1:0] run_in,
  input  wire logic [cfba_pkg::EXT_W-1:0] count,
  input  wire logic [cfba_pkg::EXT_W-1:0] lo,
  input  wire logic [cfba_pkg::EXT_W-1:0] hi,
  output cfba_pkg::scan_res_t             scan,
  output logic      [cfba_pkg::LANES-1:0] mask
);

  // Walk the lanes lowest first; stop at the first run that reaches count.
  always_comb begin
    logic [cfba_pkg::EXT_W-1:0] run;
    logic                       hit;
    logic [cfba_pkg::EXT_W-1:0] first;
    run   = run_in;
    hit   = 1'b0;
    first = '0;
    for (int i = 0; i < cfba_pkg::LANES; i++) begin
      if (!hit) begin
        if (bits[i]) begin
          run = '0;
        end else begin
          run = run + cfba_pkg::EXT_W'(1);
          if (run == count) begin
            hit   = 1'b1;
            first = base + cfba_pkg::EXT_W'(i + 1) - count;
          end
        end
      end
    end
    scan.found = hit;
    scan.first = first;
    scan.run   = run;
  end

  // Lane i covers frame base + i; select lo <= frame < hi.
  always_comb begin
    logic [cfba_pkg::EXT_W-1:0] f;
    for (int i = 0; i < cfba_pkg::LANES; i++) begin
      f       = base + cfba_pkg::EXT_W'(i);
      mask[i] = (f >= lo) && (f < hi);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/contiguous_frame_bitmap_allocator_top.sv -----
// Sequence: allocate is accepted, then scans up to ENTRIES (64) map entries,
//   then reads and writes each map entry the run touches, then posts the result.
//   Free reads and writes each map entry touched, then posts. Bad counts go straight to the result.
// Throughput: one request at a time; the scan reads through the single map
//   read port, 8 frames per cycle.
// Reset: synchronous, active low; all frames free at once (no clearing pass).
// ----------------------------------------------------------------------------
// contiguous_frame_bitmap_allocator_top: first-fit frame run allocator
// Keeps one occupancy bit per frame; allocates the lowest run of free frames
// of the asked length and frees runs on request.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_frame_bitmap_allocator_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Request words.
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [cfba_pkg::IN_TDATA_W-1:0]      in_tdata,  // start_frame[8:0], frame_count[18:9]
  input  wire logic                                 in_tuser,  // mode[0]
  // Result words.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [cfba_pkg::OUT_TDATA_W-1:0]     out_tdata, // first_frame[8:0]
  output logic                                      out_tuser  // status[0]
);

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [cfba_pkg::START_W-1:0] in_start;
  logic [cfba_pkg::COUNT_W-1:0] in_count;
  logic [cfba_pkg::EXT_W-1:0]   in_start_ext;
  logic [cfba_pkg::EXT_W-1:0]   in_count_ext;
  logic                         in_fire;

  assign in_start     = in_tdata[cfba_pkg::START_W-1:0];
  assign in_count     = in_tdata[cfba_pkg::START_W +: cfba_pkg::COUNT_W];
  assign in_start_ext = cfba_pkg::EXT_W'(in_start);
  assign in_count_ext = cfba_pkg::EXT_W'(in_count);
  assign in_fire      = in_tvalid && in_tready;

  // Last map entry of the range [lo, hi); frames past the pool are dropped.
  function automatic logic [cfba_pkg::ADDR_W-1:0] last_entry(
    input logic [cfba_pkg::EXT_W-1:0] hi
  );
    logic [cfba_pkg::EXT_W-1:0] endf;
    endf = hi - cfba_pkg::EXT_W'(1);
    if (endf > cfba_pkg::POOL_EXT - cfba_pkg::EXT_W'(1)) begin
      endf = cfba_pkg::POOL_EXT - cfba_pkg::EXT_W'(1);
    end
    return endf[cfba_pkg::LANE_SH +: cfba_pkg::ADDR_W];
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  cfba_pkg::state_t             state_r,  state_nxt;
  logic                         mode_r,   mode_nxt;
  logic [cfba_pkg::EXT_W-1:0]   count_r,  count_nxt;
  logic [cfba_pkg::EXT_W-1:0]   lo_r,     lo_nxt;
  logic [cfba_pkg::EXT_W-1:0]   hi_r,     hi_nxt;
  logic [cfba_pkg::EXT_W-1:0]   run_r,    run_nxt;
  logic [cfba_pkg::ADDR_W-1:0]  addr_r,   addr_nxt;
  logic [cfba_pkg::ADDR_W-1:0]  last_r,   last_nxt;
  logic                         res_status_r, res_status_nxt;
  logic [cfba_pkg::EXT_W-1:0]   res_first_r,  res_first_nxt;

  // Output register: parts the sequencer from the result consumer.
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_status_r, out_status_nxt;
  logic [cfba_pkg::FIRST_W-1:0] out_first_r,  out_first_nxt;
  logic                         out_load;

  // --------------------------------------------------------------------------
  // Map storage and shared unit
  // --------------------------------------------------------------------------
  logic                         rd_en;
  logic [cfba_pkg::ADDR_W-1:0]  rd_addr;
  logic [cfba_pkg::LANES-1:0]   rd_data;
  logic                         wr_en;
  logic [cfba_pkg::LANES-1:0]   wr_data;
  logic [cfba_pkg::EXT_W-1:0]   entry_base;
  cfba_pkg::scan_res_t          scan;
  logic [cfba_pkg::LANES-1:0]   mask;

  assign entry_base = cfba_pkg::EXT_W'(addr_r) << cfba_pkg::LANE_SH;

  cfba_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_data)
  );

  cfba_lane_unit u_unit (
    .bits   (rd_data),
    .base   (entry_base),
    .run_in (run_r),
    .count  (count_r),
    .lo     (lo_r),
    .hi     (hi_r),
    .scan   (scan),
    .mask   (mask)
  );

  // Allocate sets the masked frames, free clears them.
  assign wr_data = (mode_r == cfba_pkg::MODE_ALLOC) ? (rd_data | mask) : (rd_data & ~mask);

  // --------------------------------------------------------------------------
  // Sequencer: next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    run_nxt        = run_r;
    addr_nxt       = addr_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    in_tready      = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = addr_r;
    wr_en          = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      cfba_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          mode_nxt       = in_tuser;
          count_nxt      = in_count_ext;
          res_status_nxt = cfba_pkg::STAT_DONE;
          res_first_nxt  = '0;
          run_nxt        = '0;
          if (in_tuser == cfba_pkg::MODE_ALLOC) begin
            if ((in_count == '0) || (in_count_ext > cfba_pkg::POOL_EXT)) begin
              // Bad count: fail without touching the map.
              res_status_nxt = cfba_pkg::STAT_FAIL;
              state_nxt      = cfba_pkg::ST_DONE;
            end else begin
              // Start the scan at entry zero.
              addr_nxt  = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = cfba_pkg::ST_SCAN;
            end
          end else begin
            lo_nxt   = in_start_ext;
            hi_nxt   = in_start_ext + in_count_ext;
            last_nxt = last_entry(in_start_ext + in_count_ext);
            addr_nxt = in_start_ext[cfba_pkg::LANE_SH +: cfba_pkg::ADDR_W];
            if ((in_count == '0) || (in_start_ext >= cfba_pkg::POOL_EXT)) begin
              state_nxt = cfba_pkg::ST_DONE;
            end else begin
              state_nxt = cfba_pkg::ST_MARK_RD;
            end
          end
        end
      end

      cfba_pkg::ST_SCAN: begin
        if (scan.found) begin
          // Run found: mark it, report its first frame.
          lo_nxt        = scan.first;
          hi_nxt        = scan.first + count_r;
          last_nxt      = last_entry(scan.first + count_r);
          addr_nxt      = scan.first[cfba_pkg::LANE_SH +: cfba_pkg::ADDR_W];
          res_first_nxt = scan.first;
          state_nxt     = cfba_pkg::ST_MARK_RD;
        end else if (addr_r == cfba_pkg::ADDR_W'(cfba_pkg::ENTRIES - 1)) begin
          res_status_nxt = cfba_pkg::STAT_FAIL;
          state_nxt      = cfba_pkg::ST_DONE;
        end else begin
          // Carry the run into the next entry.
          run_nxt  = scan.run;
          addr_nxt = addr_r + cfba_pkg::ADDR_W'(1);
          rd_en    = 1'b1;
          rd_addr  = addr_r + cfba_pkg::ADDR_W'(1);
        end
      end

      cfba_pkg::ST_MARK_RD: begin
        rd_en     = 1'b1;
        state_nxt = cfba_pkg::ST_MARK_WR;
      end

      cfba_pkg::ST_MARK_WR: begin
        wr_en = 1'b1;
        if (addr_r == last_r) begin
          state_nxt = cfba_pkg::ST_DONE;
        end else begin
          addr_nxt  = addr_r + cfba_pkg::ADDR_W'(1);
          state_nxt = cfba_pkg::ST_MARK_RD;
        end
      end

      cfba_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = cfba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cfba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_valid_nxt  = out_valid_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_first_nxt  = res_first_r[cfba_pkg::FIRST_W-1:0];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfba_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    count_r      <= count_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    run_r        <= run_nxt;
    addr_r       <= addr_nxt;
    last_r       <= last_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = cfba_pkg::OUT_TDATA_W'(out_first_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A failed allocation reports frame zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == cfba_pkg::STAT_FAIL)) |-> (out_tdata == '0))
    else $error("failed result carries a nonzero frame");

  // The mark pass never walks past its last entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfba_pkg::ST_MARK_WR) |-> (addr_r <= last_r))
    else $error("mark pass overran its range");

  // While scanning, the carried run is always shorter than the request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfba_pkg::ST_SCAN) |-> (run_r < count_r))
    else $error("scan carried a complete run");

  // A zero-count allocate goes straight to the result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == cfba_pkg::MODE_ALLOC) && (in_count == '0))
      |=> (state_r == cfba_pkg::ST_DONE))
    else $error("zero-count allocate did not fail at once");

endmodule

`default_nettype wire

// ----- tb/sv/tb_contiguous_frame_bitmap_allocator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_frame_bitmap_allocator_top: self-checking bench for the allocator
// Drives allocate and free words with bursty pacing and stalls the result side.
// A bench-side copy of the frame map predicts every result, and each result
// is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module tb_contiguous_frame_bitmap_allocator_top;

  // One predicted result word: status in tuser, first frame in tdata.
  typedef struct packed {
    logic                         status;
    logic [cfba_pkg::FIRST_W-1:0] first_frame;
  } frame_outcome_t;

  // Receiver pacing styles; the receiver switches between them on its own.
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pace_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [cfba_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // start_frame[8:0], frame_count[18:9]
  logic                             in_tuser   = 1'b0; // mode[0]
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [cfba_pkg::OUT_TDATA_W-1:0] out_tdata;         // first_frame[8:0]
  logic                             out_tuser;         // status[0]

  // Bench copy of the occupancy map: 1 = frame in use.
  logic           frame_busy [cfba_pkg::POOL_FRAMES];
  frame_outcome_t outcome_q [$];

  // Runs handed out and not yet returned, so random traffic frees real runs.
  int             live_base [$];
  int             live_len  [$];

  int             mismatch_count = 0;
  int             burst_left     = 0;
  int             rx_hold_cycles = 0;
  int             rx_left        = 0;
  rx_pace_t       rx_mode        = RX_STEADY;

  contiguous_frame_bitmap_allocator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: apply one request to the bench map and return its result.
  // Allocation is first fit; a busy frame pushes the candidate start just
  // past it. Frees clip at the pool end and always report done.
  // --------------------------------------------------------------------------
  function automatic frame_outcome_t apply_frame_request(
    input logic                         mode,
    input logic [cfba_pkg::START_W-1:0] start,
    input logic [cfba_pkg::COUNT_W-1:0] count
  );
    frame_outcome_t res;
    int             n;
    int             base;
    int             run;
    bit             found;
    res   = '{status: cfba_pkg::STAT_DONE, first_frame: '0};
    n     = int'(count);
    base  = 0;
    found = 1'b0;
    if (mode == cfba_pkg::MODE_ALLOC) begin
      // Zero and oversize counts fail without touching the map.
      if (n != 0 && n <= cfba_pkg::POOL_FRAMES) begin
        while (!found && base + n <= cfba_pkg::POOL_FRAMES) begin
          run = 0;
          while (run < n && !frame_busy[base + run]) run++;
          if (run == n) begin
            found = 1'b1;
          end else begin
            base += run + 1;
          end
        end
      end
      if (found) begin
        for (int f = base; f < base + n; f++) frame_busy[f] = 1'b1;
        res.first_frame = cfba_pkg::FIRST_W'(base);
      end else begin
        res.status = cfba_pkg::STAT_FAIL;
      end
    end else begin
      for (int f = int'(start); f < int'(start) + n; f++) begin
        if (f < cfba_pkg::POOL_FRAMES) frame_busy[f] = 1'b0;
      end
    end
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Hold valid high across back-to-back words; lower it only in
  // a gap, so valid never drops and rises within one step.
  // --------------------------------------------------------------------------
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // About one burst in three runs straight into the next one.
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one request word, wait for the handshake, then predict its result.
  task automatic issue_request(input logic mode,
                               input logic [cfba_pkg::START_W-1:0] start,
                               input logic [cfba_pkg::COUNT_W-1:0] count,
                               output frame_outcome_t res);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= cfba_pkg::IN_TDATA_W'({count, start});
    do @(posedge clk); while (!in_tready);
    res = apply_frame_request(mode, start, count);
    outcome_q.push_back(res);
    if (mode == cfba_pkg::MODE_ALLOC && res.status == cfba_pkg::STAT_DONE) begin
      live_base.push_back(int'(res.first_frame));
      live_len.push_back(int'(count));
    end
    pace_sender();
  endtask

  // Idle the sender until every predicted result has been seen.
  task automatic wait_outcomes_drained();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Mostly short runs, some medium, a few up to the whole pool.
  function automatic int draw_run_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 95) return $urandom_range(17, 96);
    return $urandom_range(97, cfba_pkg::POOL_FRAMES);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: check accepted result words, then pick next tready.
  // A nonzero hold count forces tready low until the count runs out.
  // --------------------------------------------------------------------------
  task automatic check_outcome();
    frame_outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch($sformatf("result word with nothing outstanding: status %0b frame %0d",
                                out_tuser, out_tdata[cfba_pkg::FIRST_W-1:0]));
    end else begin
      want = outcome_q.pop_front();
      if (out_tuser !== want.status)
        report_mismatch($sformatf("status got %0b expected %0b", out_tuser, want.status));
      if (out_tdata[cfba_pkg::FIRST_W-1:0] !== want.first_frame)
        report_mismatch($sformatf("first_frame got %0d expected %0d",
                                  out_tdata[cfba_pkg::FIRST_W-1:0], want.first_frame));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_outcome();
    if (rx_left == 0) begin
      rx_mode = rx_pace_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero count, counts past the pool, and an empty free.
  task automatic test_bad_counts();
    frame_outcome_t res;
    issue_request(cfba_pkg::MODE_ALLOC, 9'd511, 10'd0, res);
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd513, res);
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd1023, res);
    issue_request(cfba_pkg::MODE_FREE, 9'd0, 10'd0, res);
  endtask

  // Build a hole and check that first fit skips it or fills it by size.
  task automatic test_first_fit();
    frame_outcome_t res;
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd3, res);
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd5, res);
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd2, res);
    issue_request(cfba_pkg::MODE_FREE, 9'd3, 10'd5, res);     // open a five-frame hole
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd6, res);    // too big, skips past the hole
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd4, res);    // lands in the hole
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd1, res);    // fills the hole's last frame
    issue_request(cfba_pkg::MODE_FREE, 9'd0, 10'd512, res);   // clears used and free frames
  endtask

  // Whole-pool runs, the last frame, frees clipped at the pool end, no-run fails.
  task automatic test_pool_extremes();
    frame_outcome_t res;
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd512, res);
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd1, res);    // pool full
    issue_request(cfba_pkg::MODE_FREE, 9'd511, 10'd1023, res); // only the last frame is in pool
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd2, res);    // one free frame, no run of two
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd1, res);    // returns the last frame
    issue_request(cfba_pkg::MODE_FREE, 9'd256, 10'd512, res); // upper half, tail clipped
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd257, res);  // 256 free, run of 257 fails
    issue_request(cfba_pkg::MODE_ALLOC, 9'd0, 10'd256, res);
    issue_request(cfba_pkg::MODE_FREE, 9'd0, 10'd512, res);
    live_base.delete();
    live_len.delete();
  endtask

  // Hold the receiver off long enough that the block backs up into tready.
  task automatic test_backpressure();
    frame_outcome_t res;
    wait_outcomes_drained();
    rx_hold_cycles = 600;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        issue_request(cfba_pkg::MODE_FREE, 9'($urandom), 10'($urandom_range(0, 24)), res);
      else
        issue_request(cfba_pkg::MODE_ALLOC, 9'($urandom), 10'(draw_run_length()), res);
    end
  endtask

  // Mostly allocate/free pairs on real runs; the rest is stray frees and bad counts.
  task automatic test_random_traffic(input int n_items);
    frame_outcome_t res;
    int             pick;
    int             idx;
    int             cnt;
    for (int i = 0; i < n_items; i++) begin
      // Pause the sender halfway until all results are back.
      if (i == n_items / 2) wait_outcomes_drained();
      pick = $urandom_range(0, 99);
      // Keep the pool from clogging with too many live runs.
      if (live_base.size() > 40 && pick < 50) pick = 50;
      if (pick < 50) begin
        issue_request(cfba_pkg::MODE_ALLOC, 9'($urandom), 10'(draw_run_length()), res);
      end else if (pick < 85 && live_base.size() > 0) begin
        idx = $urandom_range(0, live_base.size() - 1);
        issue_request(cfba_pkg::MODE_FREE, 9'(live_base[idx]), 10'(live_len[idx]), res);
        live_base.delete(idx);
        live_len.delete(idx);
      end else if (pick < 93) begin
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 32);
        issue_request(cfba_pkg::MODE_FREE, 9'($urandom), 10'(cnt), res);
      end else begin
        cnt = ($urandom_range(0, 1) == 0) ? 0 :
              $urandom_range(cfba_pkg::POOL_FRAMES + 1, 1023);
        issue_request(cfba_pkg::MODE_ALLOC, 9'($urandom), 10'(cnt), res);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int f = 0; f < cfba_pkg::POOL_FRAMES; f++) frame_busy[f] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_counts();
    test_first_fit();
    test_pool_extremes();
    test_backpressure();
    test_random_traffic(615);

    // Drain, then give a stray late word time to show up.
    wait_outcomes_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("tb_contiguous_frame_bitmap_allocator_top passed");
    end else begin
      $display("tb_contiguous_frame_bitmap_allocator_top failed");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin
    #8_000_000;
    $display("tb_contiguous_frame_bitmap_allocator_top failed");
    $finish;
  end

endmodule
